// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

    localparam int TABLE_SIZE        = 256;
    localparam int KEY_MAX_BYTES_DEF = 256;
    localparam int KEY_LEN_W         = 9;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_CLR,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_DS_RD_I,
        ST_DS_RD_J,
        ST_DS_WR_I,
        ST_DS_WR_J,
        ST_DS_RD_T,
        ST_DS_OUT
    } t_state;

    typedef struct packed {
        logic  clr;
        logic  rd_en;
        t_byte rd_addr;
        logic  wr_en;
        t_byte wr_addr;
        t_byte wr_data;
    } t_perm_req;

    typedef struct packed {
        logic  rd_en;
        t_byte rd_addr;
        logic  wr_en;
        t_byte wr_addr;
        t_byte wr_data;
    } t_key_req;

endpackage

// ===== rtl/rc4_if.sv =====
interface rc4_in_if;
    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [7:0]       key_index;
    logic [7:0]       byte_value;

    modport source (output valid, command, key_index, byte_value, input ready);
    modport sink   (input valid, command, key_index, byte_value, output ready);
endinterface

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, out_byte, input ready);
    modport sink   (input valid, out_byte, output ready);
endinterface

interface rc4_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] key_size;

    modport source (output valid, key_size, input ready);
    modport sink   (input valid, key_size, output ready);
endinterface

// ===== rtl/rc4_perm_mem.sv =====
module rc4_perm_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rc4_pkg::t_perm_req  i_req,
    output rc4_pkg::t_byte      o_rd_data
);

    rc4_pkg::t_byte                        r_mem [rc4_pkg::TABLE_SIZE];
    logic [rc4_pkg::TABLE_SIZE-1:0]        r_valid;
    rc4_pkg::t_byte                        r_rd_data;
    rc4_pkg::t_byte                        r_rd_addr;
    logic                                  r_rd_vld;

    // entries not yet written since reset or clear read as identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_valid[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule

// ===== rtl/rc4_key_mem.sv =====
module rc4_key_mem #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  rc4_pkg::t_key_req  i_req,
    output rc4_pkg::t_byte     o_rd_data
);

    localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    rc4_pkg::t_byte r_mem [KEY_MAX_BYTES];
    rc4_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[KAW-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[KAW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rc4_ctrl.sv =====
module rc4_ctrl #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rc4_pkg::KEY_LEN_W-1:0]     i_key_len,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rc4_pkg::t_cmd                     i_command,
    input  rc4_pkg::t_byte                    i_key_index,
    input  rc4_pkg::t_byte                    i_byte_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rc4_pkg::t_byte                    o_out_byte,
    output rc4_pkg::t_perm_req                o_perm_req,
    input  rc4_pkg::t_byte                    i_perm_rd,
    output rc4_pkg::t_key_req                 o_key_req,
    input  rc4_pkg::t_byte                    i_key_rd
);

    localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_MAX_L =
        rc4_pkg::KEY_LEN_W'(KEY_MAX_BYTES);

    rc4_pkg::t_state  r_state, n_state;
    rc4_pkg::t_byte   r_n, n_n;
    logic [KAW-1:0]   r_k, n_k;
    rc4_pkg::t_byte   r_i, n_i;
    rc4_pkg::t_byte   r_j, n_j;
    rc4_pkg::t_byte   r_si, n_si;
    rc4_pkg::t_byte   r_sj, n_sj;
    rc4_pkg::t_byte   r_data, n_data;
    logic             r_out_valid, n_out_valid;
    rc4_pkg::t_byte   r_out_byte, n_out_byte;

    logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
    logic [rc4_pkg::KEY_LEN_W-1:0] k_inc;
    logic                          in_xfer;
    logic                          out_free;
    rc4_pkg::t_byte                jn;

    always_comb begin
        if (i_key_len == '0) begin
            eff_len = rc4_pkg::KEY_LEN_W'(1);
        end else if (i_key_len > KEY_MAX_L) begin
            eff_len = KEY_MAX_L;
        end else begin
            eff_len = i_key_len;
        end
    end

    assign k_inc    = rc4_pkg::KEY_LEN_W'(r_k) + rc4_pkg::KEY_LEN_W'(1);
    assign in_xfer  = i_in_valid && (r_state == rc4_pkg::ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (in_xfer && i_command == rc4_pkg::CMD_START) begin
                    n_state = rc4_pkg::ST_KS_CLR;
                end else if (in_xfer && i_command == rc4_pkg::CMD_DATA) begin
                    n_state = rc4_pkg::ST_DS_RD_I;
                end
            end
            rc4_pkg::ST_KS_CLR:  n_state = rc4_pkg::ST_KS_RD_I;
            rc4_pkg::ST_KS_RD_I: n_state = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J: n_state = rc4_pkg::ST_KS_WR_I;
            rc4_pkg::ST_KS_WR_I: n_state = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J: begin
                n_state = (r_n == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD_I;
            end
            rc4_pkg::ST_DS_RD_I: n_state = rc4_pkg::ST_DS_RD_J;
            rc4_pkg::ST_DS_RD_J: n_state = rc4_pkg::ST_DS_WR_I;
            rc4_pkg::ST_DS_WR_I: n_state = rc4_pkg::ST_DS_WR_J;
            rc4_pkg::ST_DS_WR_J: n_state = rc4_pkg::ST_DS_RD_T;
            rc4_pkg::ST_DS_RD_T: n_state = rc4_pkg::ST_DS_OUT;
            rc4_pkg::ST_DS_OUT: begin
                if (out_free) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_data      = r_data;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == rc4_pkg::ST_IDLE);
        o_perm_req  = '0;
        o_key_req   = '0;
        jn          = '0;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (in_xfer && i_command == rc4_pkg::CMD_KEY) begin
                    o_key_req.wr_en   = ({1'b0, i_key_index} < KEY_MAX_L);
                    o_key_req.wr_addr = i_key_index;
                    o_key_req.wr_data = i_byte_value;
                end
                if (in_xfer && i_command == rc4_pkg::CMD_DATA) begin
                    n_data = i_byte_value;
                    n_i    = r_i + 8'd1;
                end
            end
            rc4_pkg::ST_KS_CLR: begin
                o_perm_req.clr = 1'b1;
                n_n = '0;
                n_k = '0;
                n_j = '0;
            end
            rc4_pkg::ST_KS_RD_I: begin
                o_perm_req.rd_en   = 1'b1;
                o_perm_req.rd_addr = r_n;
                o_key_req.rd_en    = 1'b1;
                o_key_req.rd_addr  = 8'(r_k);
            end
            rc4_pkg::ST_KS_RD_J: begin
                jn                 = r_j + i_perm_rd + i_key_rd;
                n_si               = i_perm_rd;
                n_j                = jn;
                o_perm_req.rd_en   = 1'b1;
                o_perm_req.rd_addr = jn;
            end
            rc4_pkg::ST_KS_WR_I: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_n;
                o_perm_req.wr_data = i_perm_rd;
            end
            rc4_pkg::ST_KS_WR_J: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_j;
                o_perm_req.wr_data = r_si;
                n_n = r_n + 8'd1;
                n_k = (k_inc >= eff_len) ? '0 : KAW'(k_inc);
                if (r_n == 8'hFF) begin
                    n_i = '0;
                    n_j = '0;
                end
            end
            rc4_pkg::ST_DS_RD_I: begin
                o_perm_req.rd_en   = 1'b1;
                o_perm_req.rd_addr = r_i;
            end
            rc4_pkg::ST_DS_RD_J: begin
                jn                 = r_j + i_perm_rd;
                n_si               = i_perm_rd;
                n_j                = jn;
                o_perm_req.rd_en   = 1'b1;
                o_perm_req.rd_addr = jn;
            end
            rc4_pkg::ST_DS_WR_I: begin
                n_sj               = i_perm_rd;
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_i;
                o_perm_req.wr_data = i_perm_rd;
            end
            rc4_pkg::ST_DS_WR_J: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_j;
                o_perm_req.wr_data = r_si;
            end
            rc4_pkg::ST_DS_RD_T: begin
                o_perm_req.rd_en   = 1'b1;
                o_perm_req.rd_addr = r_si + r_sj;
            end
            rc4_pkg::ST_DS_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ i_perm_rd;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4_pkg::ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// Key write: input ready stays high, so the next transfer is taken without a wait.
// Start: busy after the transfer for the clear state plus 256 steps (read S[i], read S[j], write both).
// Data byte: read S[i], read S[j], write S[i] and S[j], read S[t], then load the output register
// once it is free; no new byte is taken until then, as the steps share the permutation memory.
// Reset: synchronous, clears indices and output valid, restores the identity table at once,
// key length 16; key store contents are kept.
module rc4_stream_cipher #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rc4_in_if.sink      i_data_ch,
    rc4_out_if.source   o_data_ch,
    rc4_cfg_if.sink     i_cfg_ch
);

    logic [rc4_pkg::KEY_LEN_W-1:0] r_key_len;
    rc4_pkg::t_perm_req            perm_req;
    rc4_pkg::t_key_req             key_req;
    rc4_pkg::t_byte                perm_rd;
    rc4_pkg::t_byte                key_rd;
    rc4_pkg::t_cmd                 command;

    assign i_cfg_ch.ready = 1'b1;
    assign command        = rc4_pkg::t_cmd'(i_data_ch.command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= rc4_pkg::KEY_LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_key_len <= i_cfg_ch.key_size;
        end
    end

    rc4_ctrl #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_len    (r_key_len),
        .i_in_valid   (i_data_ch.valid),
        .o_in_ready   (i_data_ch.ready),
        .i_command    (command),
        .i_key_index  (i_data_ch.key_index),
        .i_byte_value (i_data_ch.byte_value),
        .o_out_valid  (o_data_ch.valid),
        .i_out_ready  (o_data_ch.ready),
        .o_out_byte   (o_data_ch.out_byte),
        .o_perm_req   (perm_req),
        .i_perm_rd    (perm_rd),
        .o_key_req    (key_req),
        .i_key_rd     (key_rd)
    );

    rc4_perm_mem u_perm_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (perm_req),
        .o_rd_data (perm_rd)
    );

    rc4_key_mem #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_req     (key_req),
        .o_rd_data (key_rd)
    );

endmodule

// ===== rtl/rc4_checker.sv =====
module rc4_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_command,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte))
        else $error("output byte changed while stalled");

    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_command == rc4_pkg::CMD_START || i_command == rc4_pkg::CMD_DATA)
        |=> !i_in_ready)
        else $error("input ready right after a start or data transfer");

    a_key_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_command == rc4_pkg::CMD_KEY |=> i_in_ready)
        else $error("key write did not return to ready");

    a_reset_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid set right after reset");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_data_ch.valid),
    .i_in_ready  (i_data_ch.ready),
    .i_command   (i_data_ch.command),
    .i_out_valid (o_data_ch.valid),
    .i_out_ready (o_data_ch.ready),
    .i_out_byte  (o_data_ch.out_byte)
);
